FILE: rtl/core/jqc_pkg.sv
// Shared types and constants of the job queue with cancel.
`default_nettype none
package jqc_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;
  localparam int DEFAULT_ID_BITS     = 16;

  localparam int CMD_W       = 2;
  localparam int PAGE_W      = 16;
  localparam int ID_W        = 16;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 5;
  localparam int OUT_TOTAL_W = 20;

  // Depth of the command queue between front and back.
  localparam int CQ_DEPTH = 2;

  typedef enum logic [CMD_W-1:0] {
    OP_ADD     = 2'd0,
    OP_PROCESS = 2'd1,
    OP_CANCEL  = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_PAGES = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // Classified command handed from front to back.
  typedef struct packed {
    op_t               op;
    logic              no_pages;
    logic [PAGE_W-1:0] pages;
    logic [ID_W-1:0]   want;
  } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/core/jqc_front.sv
// Front end: accepts input beats, classifies them and queues them for the back end.
`default_nettype none
module jqc_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [jqc_pkg::CMD_W-1:0]   command,
  input  wire logic [jqc_pkg::PAGE_W-1:0]  page_count,
  input  wire logic [jqc_pkg::ID_W-1:0]    cancel_id,
  output logic                             cmd_valid,
  input  wire logic                        cmd_ready,
  output jqc_pkg::cmd_t                    cmd
);

  localparam int PTR_W = (jqc_pkg::CQ_DEPTH > 1) ? $clog2(jqc_pkg::CQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(jqc_pkg::CQ_DEPTH + 1);

  jqc_pkg::cmd_t   item;
  jqc_pkg::cmd_t   q [jqc_pkg::CQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  always_comb begin
    item.pages    = page_count;
    item.want     = cancel_id;
    item.no_pages = (page_count == '0);
    item.op       = jqc_pkg::op_t'(command);
  end

  assign in_ready  = (count != CNT_W'(jqc_pkg::CQ_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(jqc_pkg::CQ_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(jqc_pkg::CQ_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/jqc_back.sv
// Back end: circular job store, sequencer for add, process and cancel, result register.
`default_nettype none
module jqc_back #(
  parameter int QUEUE_DEPTH = jqc_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int ID_BITS     = jqc_pkg::DEFAULT_ID_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cmd_valid,
  output logic                                  cmd_ready,
  input  wire jqc_pkg::cmd_t                    cmd,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [jqc_pkg::STATUS_W-1:0]          status,
  output logic [jqc_pkg::ID_W-1:0]              job_id,
  output logic [jqc_pkg::PAGE_W-1:0]            job_pages,
  output logic [jqc_pkg::COUNT_W-1:0]           pending_count,
  output logic [jqc_pkg::OUT_TOTAL_W-1:0]       pages_waiting
);

  localparam int PAGE_W = jqc_pkg::PAGE_W;
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = PTR_W + 1;
  localparam int TOT_W  = PAGE_W + OCC_W;
  localparam int WORD_W = ID_BITS + PAGE_W;
  localparam int CMP_W  = TOT_W + jqc_pkg::OUT_TOTAL_W;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_PROC_RD = 5'b00010,
    S_SCAN    = 5'b00100,
    S_SHIFT   = 5'b01000,
    S_RESP    = 5'b10000
  } state_t;

  state_t             state;
  logic [PTR_W-1:0]   head;
  logic [OCC_W-1:0]   occ;
  logic [TOT_W-1:0]   total;
  logic [ID_BITS-1:0] next_id;
  logic [OCC_W-1:0]   chk_pos;
  logic [ID_BITS-1:0] want;

  logic [jqc_pkg::STATUS_W-1:0] res_status;
  logic [ID_BITS-1:0]           res_id;
  logic [PAGE_W-1:0]            res_pages;

  logic [WORD_W-1:0]  mem [QUEUE_DEPTH];
  logic [WORD_W-1:0]  rdata;
  logic [WORD_W-1:0]  wdata;
  logic [PTR_W-1:0]   raddr;
  logic [PTR_W-1:0]   waddr;
  logic               mem_we;

  logic [ID_BITS-1:0] rd_id;
  logic [PAGE_W-1:0]  rd_pages;
  logic [OCC_W-1:0]   occ_m1;
  logic               is_full;
  logic               add_ok;
  logic [ID_BITS-1:0] id_inc;
  logic               slot_free;
  logic [CMP_W-1:0]   tot_ext;

  function automatic logic [PTR_W-1:0] wrap_idx(input logic [PTR_W-1:0] base,
                                                input logic [OCC_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  assign rd_id     = rdata[PAGE_W +: ID_BITS];
  assign rd_pages  = rdata[PAGE_W-1:0];
  assign occ_m1    = occ - OCC_W'(1);
  assign is_full   = (occ == OCC_W'(QUEUE_DEPTH));
  assign add_ok    = (cmd.op == jqc_pkg::OP_ADD) && !cmd.no_pages && !is_full;
  assign id_inc    = next_id + ID_BITS'(1);
  assign cmd_ready = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign tot_ext   = CMP_W'(total);

  // Store port control
  always_comb begin
    mem_we = 1'b0;
    waddr  = wrap_idx(head, occ);
    wdata  = {next_id, cmd.pages};
    raddr  = wrap_idx(head, chk_pos + OCC_W'(1));
    unique case (state)
      S_IDLE: begin
        raddr  = head;
        mem_we = cmd_valid && add_ok;
      end
      S_SHIFT: begin
        mem_we = 1'b1;
        waddr  = wrap_idx(head, chk_pos - OCC_W'(1));
        wdata  = rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Result valid: raised when a result is loaded, dropped once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_RESP && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      occ       <= '0;
      total     <= '0;
      next_id   <= ID_BITS'(1);
      chk_pos   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            res_id    <= '0;
            res_pages <= '0;
            res_status <= jqc_pkg::ST_OK;
            chk_pos   <= '0;
            want      <= ID_BITS'(cmd.want);
            state     <= S_RESP;
            unique case (cmd.op)
              jqc_pkg::OP_ADD: begin
                if (cmd.no_pages) begin
                  res_status <= jqc_pkg::ST_BAD_PAGES;
                end else if (is_full) begin
                  res_status <= jqc_pkg::ST_FULL;
                end else begin
                  res_id  <= next_id;
                  occ     <= occ + OCC_W'(1);
                  total   <= total + TOT_W'(cmd.pages);
                  next_id <= (id_inc == '0) ? ID_BITS'(1) : id_inc;
                end
              end
              jqc_pkg::OP_PROCESS: begin
                if (occ == '0) begin
                  res_status <= jqc_pkg::ST_EMPTY;
                end else begin
                  state <= S_PROC_RD;
                end
              end
              jqc_pkg::OP_CANCEL: begin
                if (occ == '0) begin
                  res_status <= jqc_pkg::ST_NOT_FOUND;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_PROC_RD: begin
          res_id    <= rd_id;
          res_pages <= rd_pages;
          head      <= wrap_idx(head, OCC_W'(1));
          occ       <= occ_m1;
          total     <= total - TOT_W'(rd_pages);
          state     <= S_RESP;
        end
        S_SCAN: begin
          // rdata holds entry chk_pos; entry chk_pos+1 is being read
          if (rd_id == want) begin
            res_id    <= rd_id;
            res_pages <= rd_pages;
            total     <= total - TOT_W'(rd_pages);
            if (chk_pos == occ_m1) begin
              occ   <= occ_m1;
              state <= S_RESP;
            end else begin
              chk_pos <= chk_pos + OCC_W'(1);
              state   <= S_SHIFT;
            end
          end else if (chk_pos == occ_m1) begin
            res_status <= jqc_pkg::ST_NOT_FOUND;
            state      <= S_RESP;
          end else begin
            chk_pos <= chk_pos + OCC_W'(1);
          end
        end
        S_SHIFT: begin
          // entry chk_pos moves down one place
          if (chk_pos == occ_m1) begin
            occ   <= occ_m1;
            state <= S_RESP;
          end else begin
            chk_pos <= chk_pos + OCC_W'(1);
          end
        end
        S_RESP: begin
          if (slot_free) begin
            status        <= res_status;
            job_id        <= jqc_pkg::ID_W'(res_id);
            job_pages     <= res_pages;
            pending_count <= jqc_pkg::COUNT_W'(occ);
            pages_waiting <= (tot_ext > CMP_W'({jqc_pkg::OUT_TOTAL_W{1'b1}})) ?
                             {jqc_pkg::OUT_TOTAL_W{1'b1}} :
                             jqc_pkg::OUT_TOTAL_W'(tot_ext);
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_W'(QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");

  a_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_id != '0)
    else $error("next job id is zero");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (chk_pos < occ))
    else $error("scan position outside queue");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (chk_pos != '0 && chk_pos < occ))
    else $error("shift position outside queue");

  a_resp_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && out_valid && !out_ready) |=> (state == S_RESP))
    else $error("result dropped while output stalled");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/job_queue_with_cancel.sv
// Top level of the job queue with cancel: front end, command queue, back end.
// Path to a result: the command queue registers the beat and the back end takes it in
// S_IDLE; process takes the head in S_PROC_RD; a cancel scans in S_SCAN and, on a hit,
// compacts the entries behind it in S_SHIFT, passing each entry once, hit or miss; a
// cancel on an empty queue goes straight to S_RESP, where the result is registered.
// One command executes at a time. A stalled result holds the back end,
// then the 2-deep command queue fills and in_ready drops.
// Reset (rst, synchronous): queue emptied, total cleared, next id set to one; job store
// contents are not cleared and need no clearing pass.
`default_nettype none
module job_queue_with_cancel #(
  parameter int QUEUE_DEPTH = jqc_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int ID_BITS     = jqc_pkg::DEFAULT_ID_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [jqc_pkg::CMD_W-1:0]        command,
  input  wire logic [jqc_pkg::PAGE_W-1:0]       page_count,
  input  wire logic [jqc_pkg::ID_W-1:0]         cancel_id,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [jqc_pkg::STATUS_W-1:0]          status,
  output logic [jqc_pkg::ID_W-1:0]              job_id,
  output logic [jqc_pkg::PAGE_W-1:0]            job_pages,
  output logic [jqc_pkg::COUNT_W-1:0]           pending_count,
  output logic [jqc_pkg::OUT_TOTAL_W-1:0]       pages_waiting
);

  // Classified beat waiting for the back end
  logic          cmd_valid;
  logic          cmd_ready;
  jqc_pkg::cmd_t cmd;

  // Front end: decode command, flag zero pages, hold up to two beats
  jqc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .page_count (page_count),
    .cancel_id  (cancel_id),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  // Back end: circular store, id counter, running page total, search and compaction
  jqc_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .job_id        (job_id),
    .job_pages     (job_pages),
    .pending_count (pending_count),
    .pages_waiting (pages_waiting)
  );

endmodule
`default_nettype wire
